### rtl/sdq_pkg.sv
// shared constants, field widths and operation codes of the subunit state deque engine
package sdq_pkg;

  // default sizing
  localparam int unsigned SDQ_MAX_SUBUNITS = 1024;
  localparam int unsigned SDQ_CODE_BITS    = 4;

  // field widths on the channels
  localparam int unsigned MODE_W   = 4;
  localparam int unsigned INST_W   = 10;
  localparam int unsigned FCODE_W  = 4;
  localparam int unsigned OUT_W    = 11;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 11;

  // largest value the 11 bit result fields can show
  localparam int unsigned OUT_MAX = (1 << OUT_W) - 1;

  // operation codes
  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_BARBED  = 4'd0,
    MODE_PUSH_POINTED = 4'd1,
    MODE_POP_BARBED   = 4'd2,
    MODE_POP_POINTED  = 4'd3,
    MODE_COUNT        = 4'd4,
    MODE_COUNT_PAIRS  = 4'd5,
    MODE_REWRITE      = 4'd6,
    MODE_REWRITE_PAIR = 4'd7,
    MODE_REFILL       = 4'd8
  } mode_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK         = 2'd0,
    STATUS_POP_EMPTY  = 2'd1,
    STATUS_PUSH_FULL  = 2'd2,
    STATUS_NTH_ABSENT = 2'd3
  } status_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INITIAL_LENGTH = 1'd0,
    CFG_INITIAL_CODE   = 1'd1
  } cfg_idx_e;

endpackage

### rtl/sdq_if.sv
// handshake interfaces for the request, response and configuration channels

// request channel: one operation word
interface sdq_req_if;
  import sdq_pkg::*;
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [INST_W-1:0]   instance_req;
  logic [FCODE_W-1:0]  match_first;
  logic [FCODE_W-1:0]  match_second;
  logic [FCODE_W-1:0]  write_first;
  logic [FCODE_W-1:0]  write_second;

  modport source (
    output valid, mode, instance_req, match_first, match_second, write_first, write_second,
    input  ready
  );
  modport sink (
    input  valid, mode, instance_req, match_first, match_second, write_first, write_second,
    output ready
  );
endinterface

// response channel: one result word
interface sdq_rsp_if;
  import sdq_pkg::*;
  logic                valid;
  logic                ready;
  logic [OUT_W-1:0]    result_value;
  logic [OUT_W-1:0]    fill_length;
  logic [FCODE_W-1:0]  pointed_end_code;
  logic [FCODE_W-1:0]  barbed_end_code;
  logic [STATUS_W-1:0] status;

  modport source (
    output valid, result_value, fill_length, pointed_end_code, barbed_end_code, status,
    input  ready
  );
  modport sink (
    input  valid, result_value, fill_length, pointed_end_code, barbed_end_code, status,
    output ready
  );
endinterface

// configuration write channel
interface sdq_cfg_if;
  import sdq_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/sdq_store.sv
// subunit ring storage: one write port and one registered read port
module sdq_store #(
  parameter int unsigned DEPTH = sdq_pkg::SDQ_MAX_SUBUNITS,
  parameter int unsigned DW    = sdq_pkg::SDQ_CODE_BITS,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_data_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/subunit_state_deque_engine_top.sv
// top level of the subunit state deque engine: sequencer around the ring storage
//
//   channel | dir | handshake     | payload
//   req_i   | in  | valid/ready   | mode, instance_req, match/write codes
//   rsp_o   | out | valid/ready   | result_value, fill_length, end codes, status
//   cfg_i   | in  | valid/ready=1 | index, data (initial_length, initial_code)
//
// push and unknown modes read both end codes; pop first takes the popped code.
// an empty store skips the end-code reads. count, pair count and rewrites stream the
// store through the single read port at one entry a cycle; refill sweeps from slot zero.
// reset leaves the store empty, so no clearing pass follows it.
// one item is in work at a time; a new word is taken while the last result waits,
// and a finished result holds the sequencer until the output register is free.
module subunit_state_deque_engine_top #(
  parameter int unsigned MAX_SUBUNITS = sdq_pkg::SDQ_MAX_SUBUNITS,
  parameter int unsigned CODE_BITS    = sdq_pkg::SDQ_CODE_BITS
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  sdq_req_if.sink  req_i,
  sdq_rsp_if.source rsp_o,
  sdq_cfg_if.sink  cfg_i
);
  import sdq_pkg::*;

  localparam int unsigned AW   = $clog2(MAX_SUBUNITS);
  localparam int unsigned CW   = $clog2(MAX_SUBUNITS + 1);
  localparam int unsigned AP1  = AW + 1;
  localparam int unsigned KW   = (CW > INST_W) ? CW : INST_W;
  localparam int unsigned SATW = (CW > OUT_W) ? CW : OUT_W;
  localparam int unsigned IW   = (CODE_BITS > FCODE_W) ? CODE_BITS : FCODE_W;
  localparam int unsigned RW   = (CODE_BITS > OUT_W) ? CODE_BITS : OUT_W;
  localparam int unsigned LW   = (CW > CFG_DATA_W) ? CW : CFG_DATA_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POP,
    ST_SCAN,
    ST_WR2,
    ST_FILL,
    ST_RD_FRONT,
    ST_RD_BACK,
    ST_CAP_BACK,
    ST_OUT
  } state_e;

  // ring index of a position counted from the pointed end
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] base, input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= AP1'(MAX_SUBUNITS)) begin
      sum = sum - AP1'(MAX_SUBUNITS);
    end
    return sum[AW-1:0];
  endfunction

  // 4 bit field code to store code
  function automatic logic [CODE_BITS-1:0] to_code(input logic [FCODE_W-1:0] f);
    logic [IW-1:0] e;
    e = IW'(f);
    return e[CODE_BITS-1:0];
  endfunction

  // store code to 4 bit field code
  function automatic logic [FCODE_W-1:0] to_field(input logic [CODE_BITS-1:0] c);
    logic [IW-1:0] e;
    e = IW'(c);
    return e[FCODE_W-1:0];
  endfunction

  // store code to 11 bit result
  function automatic logic [OUT_W-1:0] code_result(input logic [CODE_BITS-1:0] c);
    logic [RW-1:0] e;
    e = RW'(c);
    return e[OUT_W-1:0];
  endfunction

  // count to 11 bit result, saturating
  function automatic logic [OUT_W-1:0] sat_out(input logic [CW-1:0] v);
    logic [SATW-1:0] e;
    e = SATW'(v);
    if (e > SATW'(OUT_MAX)) begin
      return OUT_W'(OUT_MAX);
    end
    return e[OUT_W-1:0];
  endfunction

  // state and working registers
  state_e                state_q, state_d;
  logic [AW-1:0]         front_q, front_d;
  logic [CW-1:0]         occ_q, occ_d;
  logic [CFG_DATA_W-1:0] cfg_len_q, cfg_len_d;
  logic [FCODE_W-1:0]    cfg_code_q, cfg_code_d;
  logic [MODE_W-1:0]     mode_q, mode_d;
  logic [INST_W-1:0]     inst_q, inst_d;
  logic [CODE_BITS-1:0]  m1_q, m1_d, m2_q, m2_d, w1_q, w1_d, w2_q, w2_d;
  logic [CW-1:0]         iss_q, iss_d;
  logic [CW-1:0]         pos_q, pos_d;
  logic                  dv_q, dv_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic                  prev_ok_q, prev_ok_d;
  logic [CODE_BITS-1:0]  prev_q, prev_d;
  logic [AW-1:0]         wr2_addr_q, wr2_addr_d;
  logic [OUT_W-1:0]      res_q, res_d;
  status_e               stat_q, stat_d;
  logic [FCODE_W-1:0]    fcode_q, fcode_d, bcode_q, bcode_d;

  // output register
  logic                  out_valid_q, out_valid_d;
  logic [OUT_W-1:0]      out_res_q, out_res_d;
  logic [OUT_W-1:0]      out_fill_q, out_fill_d;
  logic [FCODE_W-1:0]    out_pcode_q, out_pcode_d;
  logic [FCODE_W-1:0]    out_bcode_q, out_bcode_d;
  logic [STATUS_W-1:0]   out_stat_q, out_stat_d;

  // storage ports
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [CODE_BITS-1:0]  wr_data;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [CODE_BITS-1:0]  rd_data;

  // scan helpers
  logic                  in_fire;
  logic                  hit_one;
  logic                  hit_pair;
  logic [CW-1:0]         occ_m1;
  logic [CW-1:0]         pos_m1;
  logic [LW-1:0]         fill_n;

  sdq_store #(
    .DEPTH (MAX_SUBUNITS),
    .DW    (CODE_BITS),
    .AW    (AW)
  ) u_sdq_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // handshakes
  assign req_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_fire     = req_i.valid && (state_q == ST_IDLE);

  assign occ_m1   = occ_q - 1'b1;
  assign pos_m1   = pos_q - 1'b1;
  assign hit_one  = (rd_data == m1_q);
  assign hit_pair = prev_ok_q && (prev_q == m1_q) && (rd_data == m2_q);
  assign fill_n   = (LW'(cfg_len_q) > LW'(MAX_SUBUNITS)) ? LW'(MAX_SUBUNITS) : LW'(cfg_len_q);

  // sequencer next state
  always_comb begin
    state_d     = state_q;
    front_d     = front_q;
    occ_d       = occ_q;
    cfg_len_d   = cfg_len_q;
    cfg_code_d  = cfg_code_q;
    mode_d      = mode_q;
    inst_d      = inst_q;
    m1_d        = m1_q;
    m2_d        = m2_q;
    w1_d        = w1_q;
    w2_d        = w2_q;
    iss_d       = iss_q;
    pos_d       = pos_q;
    dv_d        = 1'b0;
    cnt_d       = cnt_q;
    prev_ok_d   = prev_ok_q;
    prev_d      = prev_q;
    wr2_addr_d  = wr2_addr_q;
    res_d       = res_q;
    stat_d      = stat_q;
    fcode_d     = fcode_q;
    bcode_d     = bcode_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_res_d   = out_res_q;
    out_fill_d  = out_fill_q;
    out_pcode_d = out_pcode_q;
    out_bcode_d = out_bcode_q;
    out_stat_d  = out_stat_q;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = '0;
    rd_en       = 1'b0;
    rd_addr     = '0;

    // configuration writes
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_INITIAL_LENGTH: cfg_len_d  = cfg_i.data;
        CFG_INITIAL_CODE:   cfg_code_d = cfg_i.data[FCODE_W-1:0];
        default: ;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          mode_d    = req_i.mode;
          inst_d    = req_i.instance_req;
          m1_d      = to_code(req_i.match_first);
          m2_d      = to_code(req_i.match_second);
          w1_d      = to_code(req_i.write_first);
          w2_d      = to_code(req_i.write_second);
          res_d     = '0;
          stat_d    = STATUS_OK;
          iss_d     = '0;
          cnt_d     = '0;
          prev_ok_d = 1'b0;
          state_d   = ST_RD_FRONT;
          unique case (req_i.mode)
            MODE_PUSH_BARBED: begin
              if (occ_q == CW'(MAX_SUBUNITS)) begin
                stat_d = STATUS_PUSH_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_addr = slot(front_q, occ_q[AW-1:0]);
                wr_data = to_code(req_i.write_first);
                occ_d   = occ_q + 1'b1;
              end
            end
            MODE_PUSH_POINTED: begin
              if (occ_q == CW'(MAX_SUBUNITS)) begin
                stat_d = STATUS_PUSH_FULL;
              end else begin
                front_d = (front_q == '0) ? AW'(MAX_SUBUNITS - 1) : front_q - 1'b1;
                wr_en   = 1'b1;
                wr_addr = front_d;
                wr_data = to_code(req_i.write_first);
                occ_d   = occ_q + 1'b1;
              end
            end
            MODE_POP_BARBED: begin
              if (occ_q == '0) begin
                stat_d = STATUS_POP_EMPTY;
              end else begin
                rd_en   = 1'b1;
                rd_addr = slot(front_q, occ_m1[AW-1:0]);
                occ_d   = occ_m1;
                state_d = ST_POP;
              end
            end
            MODE_POP_POINTED: begin
              if (occ_q == '0) begin
                stat_d = STATUS_POP_EMPTY;
              end else begin
                rd_en   = 1'b1;
                rd_addr = front_q;
                front_d = slot(front_q, AW'(1));
                occ_d   = occ_m1;
                state_d = ST_POP;
              end
            end
            MODE_COUNT, MODE_COUNT_PAIRS: begin
              state_d = ST_SCAN;
            end
            MODE_REWRITE, MODE_REWRITE_PAIR: begin
              stat_d  = STATUS_NTH_ABSENT;
              state_d = ST_SCAN;
            end
            MODE_REFILL: begin
              front_d = '0;
              occ_d   = fill_n[CW-1:0];
              state_d = ST_FILL;
            end
            default: ;
          endcase
        end
      end

      // popped code arrives from the read port
      ST_POP: begin
        res_d   = code_result(rd_data);
        state_d = ST_RD_FRONT;
      end

      // stream entries: issue one read a cycle, check the one that returns
      ST_SCAN: begin
        if (iss_q < occ_q) begin
          rd_en   = 1'b1;
          rd_addr = slot(front_q, iss_q[AW-1:0]);
          iss_d   = iss_q + 1'b1;
          pos_d   = iss_q;
          dv_d    = 1'b1;
        end
        if (dv_q) begin
          if ((mode_q == MODE_COUNT) || (mode_q == MODE_REWRITE)) begin
            if (hit_one) begin
              if ((mode_q == MODE_REWRITE) && (KW'(cnt_q) == KW'(inst_q))) begin
                wr_en   = 1'b1;
                wr_addr = slot(front_q, pos_q[AW-1:0]);
                wr_data = w1_q;
                stat_d  = STATUS_OK;
                state_d = ST_RD_FRONT;
              end else begin
                cnt_d = cnt_q + 1'b1;
              end
            end
          end else begin
            if (hit_pair) begin
              if ((mode_q == MODE_REWRITE_PAIR) && (KW'(cnt_q) == KW'(inst_q))) begin
                wr_en      = 1'b1;
                wr_addr    = slot(front_q, pos_m1[AW-1:0]);
                wr_data    = w1_q;
                wr2_addr_d = slot(front_q, pos_q[AW-1:0]);
                stat_d     = STATUS_OK;
                state_d    = ST_WR2;
              end else begin
                cnt_d     = cnt_q + 1'b1;
                prev_ok_d = 1'b0;
              end
            end else begin
              prev_ok_d = 1'b1;
              prev_d    = rd_data;
            end
          end
        end else if (iss_q == occ_q) begin
          // every entry has been checked
          if ((mode_q == MODE_COUNT) || (mode_q == MODE_COUNT_PAIRS)) begin
            res_d = sat_out(cnt_q);
          end
          state_d = ST_RD_FRONT;
        end
      end

      // barbed side of a rewritten pair
      ST_WR2: begin
        wr_en   = 1'b1;
        wr_addr = wr2_addr_q;
        wr_data = w2_q;
        state_d = ST_RD_FRONT;
      end

      // refill sweep from slot zero
      ST_FILL: begin
        if (iss_q < occ_q) begin
          wr_en   = 1'b1;
          wr_addr = iss_q[AW-1:0];
          wr_data = to_code(cfg_code_q);
          iss_d   = iss_q + 1'b1;
        end else begin
          state_d = ST_RD_FRONT;
        end
      end

      // fetch both end codes
      ST_RD_FRONT: begin
        if (occ_q == '0) begin
          fcode_d = '0;
          bcode_d = '0;
          state_d = ST_OUT;
        end else begin
          rd_en   = 1'b1;
          rd_addr = front_q;
          state_d = ST_RD_BACK;
        end
      end

      ST_RD_BACK: begin
        fcode_d = to_field(rd_data);
        rd_en   = 1'b1;
        rd_addr = slot(front_q, occ_m1[AW-1:0]);
        state_d = ST_CAP_BACK;
      end

      ST_CAP_BACK: begin
        bcode_d = to_field(rd_data);
        state_d = ST_OUT;
      end

      // hand the result to the output register once it is free
      ST_OUT: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d = 1'b1;
          out_res_d   = res_q;
          out_fill_d  = sat_out(occ_q);
          out_pcode_d = fcode_q;
          out_bcode_d = bcode_q;
          out_stat_d  = stat_q;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // state, working and output registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      front_q     <= '0;
      occ_q       <= '0;
      cfg_len_q   <= '0;
      cfg_code_q  <= '0;
      iss_q       <= '0;
      dv_q        <= 1'b0;
      cnt_q       <= '0;
      prev_ok_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      occ_q       <= occ_d;
      cfg_len_q   <= cfg_len_d;
      cfg_code_q  <= cfg_code_d;
      iss_q       <= iss_d;
      dv_q        <= dv_d;
      cnt_q       <= cnt_d;
      prev_ok_q   <= prev_ok_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    mode_q      <= mode_d;
    inst_q      <= inst_d;
    m1_q        <= m1_d;
    m2_q        <= m2_d;
    w1_q        <= w1_d;
    w2_q        <= w2_d;
    pos_q       <= pos_d;
    prev_q      <= prev_d;
    wr2_addr_q  <= wr2_addr_d;
    res_q       <= res_d;
    stat_q      <= stat_d;
    fcode_q     <= fcode_d;
    bcode_q     <= bcode_d;
    out_res_q   <= out_res_d;
    out_fill_q  <= out_fill_d;
    out_pcode_q <= out_pcode_d;
    out_bcode_q <= out_bcode_d;
    out_stat_q  <= out_stat_d;
  end

  // response channel
  assign rsp_o.valid            = out_valid_q;
  assign rsp_o.result_value     = out_res_q;
  assign rsp_o.fill_length      = out_fill_q;
  assign rsp_o.pointed_end_code = out_pcode_q;
  assign rsp_o.barbed_end_code  = out_bcode_q;
  assign rsp_o.status           = out_stat_q;

endmodule

### rtl/sdq_checker.sv
// port level assertions for the subunit state deque engine, bound to the top level
module sdq_checker #(
  parameter int unsigned MAX_SUBUNITS = sdq_pkg::SDQ_MAX_SUBUNITS
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic [sdq_pkg::OUT_W-1:0]     result_value_i,
  input logic [sdq_pkg::OUT_W-1:0]     fill_length_i,
  input logic [sdq_pkg::FCODE_W-1:0]   pointed_end_code_i,
  input logic [sdq_pkg::FCODE_W-1:0]   barbed_end_code_i,
  input logic [sdq_pkg::STATUS_W-1:0]  status_i
);
  import sdq_pkg::*;

  localparam int unsigned FULL_SHOWN = (MAX_SUBUNITS > OUT_MAX) ? OUT_MAX : MAX_SUBUNITS;

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(result_value_i)
      && $stable(fill_length_i) && $stable(status_i))
  else $error("stalled result word changed");

  // an empty store shows zero end codes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (fill_length_i == '0) |->
      (pointed_end_code_i == '0) && (barbed_end_code_i == '0))
  else $error("empty store with nonzero end code");

  // pop from empty reports an empty store and no value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i == STATUS_POP_EMPTY) |->
      (fill_length_i == '0) && (result_value_i == '0))
  else $error("pop from empty with data or length");

  // push refused only on a full store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i == STATUS_PUSH_FULL) |->
      (fill_length_i == OUT_W'(FULL_SHOWN)) && (result_value_i == '0))
  else $error("push refused on a store that is not full");

endmodule

bind subunit_state_deque_engine_top sdq_checker #(
  .MAX_SUBUNITS (MAX_SUBUNITS)
) u_sdq_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .rsp_valid_i        (rsp_o.valid),
  .rsp_ready_i        (rsp_o.ready),
  .result_value_i     (rsp_o.result_value),
  .fill_length_i      (rsp_o.fill_length),
  .pointed_end_code_i (rsp_o.pointed_end_code),
  .barbed_end_code_i  (rsp_o.barbed_end_code),
  .status_i           (rsp_o.status)
);
